FILE: design/qxmm_pkg.sv
// ----------------------------------------------------------------------------
// qxmm_pkg: shared types and constants of the quad X motor mixer
// Fixed-point widths, register indexes and the side-band struct that travels
// alongside the scale dividers.
// ----------------------------------------------------------------------------
package qxmm_pkg;

    // Q format
    localparam int FRAC_BITS = 16;

    // port widths
    localparam int IN_W   = 18;
    localparam int OUT_W  = 17;
    localparam int MIN_W  = 16;
    localparam int MAX_W  = 17;
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    // 1.0 in Q16
    localparam logic [OUT_W-1:0] ONE = OUT_W'(2 ** FRAC_BITS);

    // internal widths
    localparam int DEV_W = 20;   // +-r +-p +-y
    localparam int NUM_W = 18;   // limit minus throttle
    localparam int DVS_W = 19;   // divisor magnitude
    localparam int DVD_W = 34;   // dividend magnitude, padded to even
    localparam int QUO_W = 34;   // signed scale
    localparam int E1_W  = 40;   // deviation after the upper scaling
    localparam int E2_W  = 49;   // deviation after the lower scaling
    localparam int P_W   = 64;   // wrapping product of the lower scaling

    // divider: two quotient bits per stage, plus entry and exit stages
    localparam int DIV_STEPS = DVD_W / 2;
    localparam int DIV_LAT   = DIV_STEPS + 2;

    // register indexes (paddr[2])
    localparam logic REG_MIN_LIMIT = 1'b0;
    localparam logic REG_MAX_LIMIT = 1'b1;

    // data that rides along with an item while its scales are divided
    typedef struct packed {
        logic                       flag_hi;
        logic                       flag_lo;
        logic [OUT_W-1:0]           t;
        logic [3:0][DEV_W-1:0]      dev;
    } side_t;

endpackage

FILE: design/qxmm_div.sv
// ----------------------------------------------------------------------------
// qxmm_div: pipelined scale divider
// Computes (num * 2^FRAC_BITS) / den, truncated toward zero, two restoring
// steps per stage. A zero divisor yields zero. One item may enter each cycle.
// ----------------------------------------------------------------------------
module qxmm_div (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    input  logic signed [qxmm_pkg::NUM_W-1:0]     num,
    input  logic signed [qxmm_pkg::DEV_W-1:0]     den,
    output logic                                  out_valid,
    output logic signed [qxmm_pkg::QUO_W-1:0]     quo
);
    import qxmm_pkg::*;

    logic             valid_reg [DIV_STEPS+1];
    logic [DVS_W-1:0] rem_reg   [DIV_STEPS+1];
    logic [DVD_W-1:0] dvd_reg   [DIV_STEPS+1];
    logic [DVS_W-1:0] dvs_reg   [DIV_STEPS+1];
    logic             neg_reg   [DIV_STEPS+1];
    logic             zero_reg  [DIV_STEPS+1];

    logic                    out_valid_reg;
    logic signed [QUO_W-1:0] quo_reg;

    logic [NUM_W-1:0] num_mag;
    logic [DEV_W-1:0] den_mag;

    // entry: magnitudes and sign of the quotient
    assign num_mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    assign den_mag = den[DEV_W-1] ? DEV_W'(-den) : DEV_W'(den);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else
        begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0]  <= '0;
        dvd_reg[0]  <= DVD_W'(num_mag) << FRAC_BITS;
        dvs_reg[0]  <= den_mag[DVS_W-1:0];
        neg_reg[0]  <= num[NUM_W-1] ^ den[DEV_W-1];
        zero_reg[0] <= (den == '0);
    end

    // restoring steps; quotient bits shift in as dividend bits shift out
    for (genvar g = 0; g < DIV_STEPS; g++)
    begin : g_step
        logic [DVS_W-1:0] rem_next;
        logic [DVD_W-1:0] dvd_next;

        always_comb
        begin : step_calc
            logic [DVS_W:0]   trial;
            logic [DVS_W-1:0] rem;
            logic [DVD_W-1:0] dvd;
            rem = rem_reg[g];
            dvd = dvd_reg[g];
            for (int b = 0; b < 2; b++)
            begin
                trial = {rem, dvd[DVD_W-1]};
                dvd   = {dvd[DVD_W-2:0], 1'b0};
                if (trial >= {1'b0, dvs_reg[g]})
                begin
                    rem    = DVS_W'(trial - {1'b0, dvs_reg[g]});
                    dvd[0] = 1'b1;
                end
                else
                begin
                    rem = trial[DVS_W-1:0];
                end
            end
            rem_next = rem;
            dvd_next = dvd;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[g+1] <= 1'b0;
            end
            else
            begin
                valid_reg[g+1] <= valid_reg[g];
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[g+1]  <= rem_next;
            dvd_reg[g+1]  <= dvd_next;
            dvs_reg[g+1]  <= dvs_reg[g];
            neg_reg[g+1]  <= neg_reg[g];
            zero_reg[g+1] <= zero_reg[g];
        end
    end

    // exit: apply sign, force zero on a zero divisor
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= valid_reg[DIV_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (zero_reg[DIV_STEPS])
        begin
            quo_reg <= '0;
        end
        else if (neg_reg[DIV_STEPS])
        begin
            quo_reg <= -$signed(dvd_reg[DIV_STEPS]);
        end
        else
        begin
            quo_reg <= $signed(dvd_reg[DIV_STEPS]);
        end
    end

    assign out_valid = out_valid_reg;
    assign quo       = quo_reg;

endmodule

FILE: design/quad_x_motor_mixer.sv
// ----------------------------------------------------------------------------
// quad_x_motor_mixer: quad X frame motor mixer with desaturation
// Mixes throttle, roll, pitch and yaw into four Q16 motor commands and scales
// the corrections back when a motor leaves the min/max limits.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive throttle_in, roll_cmd, pitch_cmd, yaw_cmd and pulse start.
//   An item is taken at each rising edge with start high and busy low; busy
//   stays low, so an item may enter on every cycle.
//   Output: done is high for one cycle with the four motor commands; the
//   receiver cannot stall, results simply flow out in input order.
//   Path: stage 1, the two scale dividers, A1, A2, B1 to B4, then the done register.
//   Throughput: one item per cycle. The depth is set by the two scale
//   dividers (two quotient bits per stage) followed by the multiply stages.
//   Configuration: APB writes to min_limit (0x0) and max_limit (0x4); write
//   only while no item is in flight. A max_limit of zero or above 1.0 is
//   ignored.
//   Reset: clears the pipeline valid bits, min_limit to 0, max_limit to 1.0.
// ----------------------------------------------------------------------------
module quad_x_motor_mixer (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic signed [qxmm_pkg::IN_W-1:0]       throttle_in,
    input  logic signed [qxmm_pkg::IN_W-1:0]       roll_cmd,
    input  logic signed [qxmm_pkg::IN_W-1:0]       pitch_cmd,
    input  logic signed [qxmm_pkg::IN_W-1:0]       yaw_cmd,
    output logic                                   done,
    output logic [qxmm_pkg::OUT_W-1:0]             motor_front_right,
    output logic [qxmm_pkg::OUT_W-1:0]             motor_front_left,
    output logic [qxmm_pkg::OUT_W-1:0]             motor_rear_right,
    output logic [qxmm_pkg::OUT_W-1:0]             motor_rear_left,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [qxmm_pkg::ADDR_W-1:0]            paddr,
    input  logic [qxmm_pkg::DATA_W-1:0]            pwdata,
    output logic [qxmm_pkg::DATA_W-1:0]            prdata,
    output logic                                   pready
);
    import qxmm_pkg::*;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic             cfg_write;
    logic [MIN_W-1:0] min_limit_reg;
    logic [MAX_W-1:0] max_limit_reg;
    logic [MAX_W-1:0] max_wdata;

    assign cfg_write = psel & penable & pwrite & pready;
    assign max_wdata = pwdata[MAX_W-1:0];
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_limit_reg <= '0;
            max_limit_reg <= ONE;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_MIN_LIMIT: min_limit_reg <= pwdata[MIN_W-1:0];
                REG_MAX_LIMIT:
                begin
                    if (max_wdata != '0 && max_wdata <= ONE)
                    begin
                        max_limit_reg <= max_wdata;
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_MIN_LIMIT: prdata = DATA_W'(min_limit_reg);
            REG_MAX_LIMIT: prdata = DATA_W'(max_limit_reg);
            default:       prdata = '0;
        endcase
    end

    assign busy = 1'b0;

    // ------------------------------------------------------------------
    // stage 1: clamp throttle, mix deviations, find peak and trough
    // ------------------------------------------------------------------
    logic [OUT_W-1:0]          t_clamp;
    logic signed [DEV_W-1:0]   r_x, p_x, y_x;
    logic signed [DEV_W-1:0]   dev_c [4];
    logic signed [DEV_W-1:0]   max_a, max_b, min_a, min_b;

    always_comb
    begin
        if (throttle_in[IN_W-1])
        begin
            t_clamp = '0;
        end
        else if (throttle_in > $signed({1'b0, ONE}))
        begin
            t_clamp = ONE;
        end
        else
        begin
            t_clamp = throttle_in[OUT_W-1:0];
        end
        r_x = DEV_W'(roll_cmd);
        p_x = DEV_W'(pitch_cmd);
        y_x = DEV_W'(yaw_cmd);
        dev_c[0] =  r_x - p_x - y_x;
        dev_c[1] = -r_x - p_x + y_x;
        dev_c[2] =  r_x + p_x + y_x;
        dev_c[3] = -r_x + p_x - y_x;
        max_a = (dev_c[1] > dev_c[0]) ? dev_c[1] : dev_c[0];
        max_b = (dev_c[3] > dev_c[2]) ? dev_c[3] : dev_c[2];
        min_a = (dev_c[1] < dev_c[0]) ? dev_c[1] : dev_c[0];
        min_b = (dev_c[3] < dev_c[2]) ? dev_c[3] : dev_c[2];
    end

    logic                      p1_valid_reg;
    logic [OUT_W-1:0]          p1_t_reg;
    logic [3:0][DEV_W-1:0]     p1_dev_reg;
    logic signed [DEV_W-1:0]   p1_max_reg;
    logic signed [DEV_W-1:0]   p1_min_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
        end
        else
        begin
            p1_valid_reg <= start & ~busy;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_t_reg   <= t_clamp;
        for (int i = 0; i < 4; i++)
        begin
            p1_dev_reg[i] <= dev_c[i];
        end
        p1_max_reg <= (max_b > max_a) ? max_b : max_a;
        p1_min_reg <= (min_b < min_a) ? min_b : min_a;
    end

    // ------------------------------------------------------------------
    // scale divisions and desaturation flags
    // ------------------------------------------------------------------
    logic signed [DEV_W:0]   t_w, peak_w, trough_w;
    logic signed [NUM_W-1:0] num_hi, num_lo;
    logic signed [DEV_W-1:0] den_lo;
    side_t                   side_in;

    always_comb
    begin
        t_w      = $signed({4'b0, p1_t_reg});
        peak_w   = t_w + (DEV_W+1)'(p1_max_reg);
        trough_w = t_w + (DEV_W+1)'(p1_min_reg);
        num_hi   = NUM_W'($signed({1'b0, max_limit_reg}) - $signed({1'b0, p1_t_reg}));
        num_lo   = NUM_W'($signed({1'b0, p1_t_reg}) - $signed({2'b0, min_limit_reg}));
        den_lo   = -p1_min_reg;
        side_in.flag_hi = peak_w > $signed({4'b0, max_limit_reg});
        side_in.flag_lo = trough_w < $signed({5'b0, min_limit_reg});
        side_in.t       = p1_t_reg;
        side_in.dev     = p1_dev_reg;
    end

    logic                    div_hi_valid, div_lo_valid;
    logic signed [QUO_W-1:0] scale_hi, scale_lo;

    qxmm_div u_div_hi (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (p1_valid_reg),
        .num       (num_hi),
        .den       (p1_max_reg),
        .out_valid (div_hi_valid),
        .quo       (scale_hi)
    );

    qxmm_div u_div_lo (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (p1_valid_reg),
        .num       (num_lo),
        .den       (den_lo),
        .out_valid (div_lo_valid),
        .quo       (scale_lo)
    );

    // side data delayed to match the dividers
    side_t side_reg [DIV_LAT];

    always_ff @(posedge clk)
    begin
        side_reg[0] <= side_in;
        for (int i = 1; i < DIV_LAT; i++)
        begin
            side_reg[i] <= side_reg[i-1];
        end
    end

    side_t side_d;
    assign side_d = side_reg[DIV_LAT-1];

    // ------------------------------------------------------------------
    // A1: deviation times upper scale, split in two partial products
    // ------------------------------------------------------------------
    logic                            a1_valid_reg;
    logic signed [37:0]              a1_pl_reg [4];
    logic signed [36:0]              a1_ph_reg [4];
    logic [3:0][DEV_W-1:0]           a1_dev_reg;
    logic [OUT_W-1:0]                a1_t_reg;
    logic                            a1_flag_hi_reg, a1_flag_lo_reg;
    logic signed [QUO_W-1:0]         a1_scale_lo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a1_valid_reg <= 1'b0;
        end
        else
        begin
            a1_valid_reg <= div_hi_valid & div_lo_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
        begin
            a1_pl_reg[i] <= $signed(side_d.dev[i]) * $signed({1'b0, scale_hi[16:0]});
            a1_ph_reg[i] <= $signed(side_d.dev[i]) * $signed(scale_hi[QUO_W-1:17]);
        end
        a1_dev_reg      <= side_d.dev;
        a1_t_reg        <= side_d.t;
        a1_flag_hi_reg  <= side_d.flag_hi;
        a1_flag_lo_reg  <= side_d.flag_lo;
        a1_scale_lo_reg <= scale_lo;
    end

    // ------------------------------------------------------------------
    // A2: sum, truncate toward zero, select scaled or raw deviation
    // ------------------------------------------------------------------
    logic signed [E1_W-1:0] e1_c [4];

    always_comb
    begin : a2_calc
        logic signed [54:0] lo_x, hi_x, prod, biased;
        for (int i = 0; i < 4; i++)
        begin
            lo_x   = a1_pl_reg[i];
            hi_x   = a1_ph_reg[i];
            prod   = lo_x + (hi_x <<< 17);
            biased = prod[54] ? prod + 55'(ONE - 1'b1) : prod;
            if (a1_flag_hi_reg)
            begin
                e1_c[i] = E1_W'($signed(biased[54:FRAC_BITS]));
            end
            else
            begin
                e1_c[i] = E1_W'($signed(a1_dev_reg[i]));
            end
        end
    end

    logic                    a2_valid_reg;
    logic signed [E1_W-1:0]  a2_e1_reg [4];
    logic [OUT_W-1:0]        a2_t_reg;
    logic                    a2_flag_lo_reg;
    logic signed [QUO_W-1:0] a2_scale_lo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a2_valid_reg <= 1'b0;
        end
        else
        begin
            a2_valid_reg <= a1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a2_e1_reg       <= e1_c;
        a2_t_reg        <= a1_t_reg;
        a2_flag_lo_reg  <= a1_flag_lo_reg;
        a2_scale_lo_reg <= a1_scale_lo_reg;
    end

    // ------------------------------------------------------------------
    // B1: deviation times lower scale, four partial products
    // ------------------------------------------------------------------
    logic                   b1_valid_reg;
    logic [39:0]            b1_ll_reg [4];
    logic signed [40:0]     b1_lh_reg [4];
    logic signed [34:0]     b1_hl_reg [4];
    logic signed [33:0]     b1_hh_reg [4];
    logic signed [E1_W-1:0] b1_e1_reg [4];
    logic [OUT_W-1:0]       b1_t_reg;
    logic                   b1_flag_lo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg <= 1'b0;
        end
        else
        begin
            b1_valid_reg <= a2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
        begin
            b1_ll_reg[i] <= 40'(a2_e1_reg[i][22:0]) * 40'(a2_scale_lo_reg[16:0]);
            b1_lh_reg[i] <= $signed({1'b0, a2_e1_reg[i][22:0]})
                            * $signed(a2_scale_lo_reg[QUO_W-1:17]);
            b1_hl_reg[i] <= $signed(a2_e1_reg[i][E1_W-1:23])
                            * $signed({1'b0, a2_scale_lo_reg[16:0]});
            b1_hh_reg[i] <= $signed(a2_e1_reg[i][E1_W-1:23])
                            * $signed(a2_scale_lo_reg[QUO_W-1:17]);
        end
        b1_e1_reg      <= a2_e1_reg;
        b1_t_reg       <= a2_t_reg;
        b1_flag_lo_reg <= a2_flag_lo_reg;
    end

    // ------------------------------------------------------------------
    // B2: pairwise sums, 64-bit wrap
    // ------------------------------------------------------------------
    logic signed [P_W-1:0] sa_c [4];
    logic signed [P_W-1:0] sb_c [4];

    always_comb
    begin : b2_calc
        logic signed [P_W-1:0] lh_x, hl_x, hh_x;
        for (int i = 0; i < 4; i++)
        begin
            lh_x    = b1_lh_reg[i];
            hl_x    = b1_hl_reg[i];
            hh_x    = b1_hh_reg[i];
            sa_c[i] = $signed(P_W'(b1_ll_reg[i])) + (lh_x <<< 17);
            sb_c[i] = (hl_x <<< 23) + (hh_x <<< 40);
        end
    end

    logic                   b2_valid_reg;
    logic signed [P_W-1:0]  b2_sa_reg [4];
    logic signed [P_W-1:0]  b2_sb_reg [4];
    logic signed [E1_W-1:0] b2_e1_reg [4];
    logic [OUT_W-1:0]       b2_t_reg;
    logic                   b2_flag_lo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b2_valid_reg <= 1'b0;
        end
        else
        begin
            b2_valid_reg <= b1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        b2_sa_reg      <= sa_c;
        b2_sb_reg      <= sb_c;
        b2_e1_reg      <= b1_e1_reg;
        b2_t_reg       <= b1_t_reg;
        b2_flag_lo_reg <= b1_flag_lo_reg;
    end

    // ------------------------------------------------------------------
    // B3: final product sum
    // ------------------------------------------------------------------
    logic                   b3_valid_reg;
    logic signed [P_W-1:0]  b3_p_reg  [4];
    logic signed [E1_W-1:0] b3_e1_reg [4];
    logic [OUT_W-1:0]       b3_t_reg;
    logic                   b3_flag_lo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b3_valid_reg <= 1'b0;
        end
        else
        begin
            b3_valid_reg <= b2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
        begin
            b3_p_reg[i] <= b2_sa_reg[i] + b2_sb_reg[i];
        end
        b3_e1_reg      <= b2_e1_reg;
        b3_t_reg       <= b2_t_reg;
        b3_flag_lo_reg <= b2_flag_lo_reg;
    end

    // ------------------------------------------------------------------
    // B4: truncate toward zero, or pass the deviation on when flag_lo is clear; the
    // most negative product negates to itself, so its quotient flips sign
    // ------------------------------------------------------------------
    logic signed [E2_W-1:0] e2_c [4];

    always_comb
    begin : b4_calc
        logic signed [P_W-1:0] biased;
        for (int i = 0; i < 4; i++)
        begin
            biased = b3_p_reg[i][P_W-1] ? b3_p_reg[i] + P_W'(ONE - 1'b1) : b3_p_reg[i];
            if (!b3_flag_lo_reg)
            begin
                e2_c[i] = E2_W'(b3_e1_reg[i]);
            end
            else if (b3_p_reg[i] == {1'b1, {(P_W-1){1'b0}}})
            begin
                e2_c[i] = E2_W'(1) <<< (P_W - 1 - FRAC_BITS);
            end
            else
            begin
                e2_c[i] = E2_W'($signed(biased[P_W-1:FRAC_BITS]));
            end
        end
    end

    logic                   b4_valid_reg;
    logic signed [E2_W-1:0] b4_e2_reg [4];
    logic [OUT_W-1:0]       b4_t_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b4_valid_reg <= 1'b0;
        end
        else
        begin
            b4_valid_reg <= b3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        b4_e2_reg <= e2_c;
        b4_t_reg  <= b3_t_reg;
    end

    // ------------------------------------------------------------------
    // B5: add throttle back, clamp low bound first then high bound
    // ------------------------------------------------------------------
    logic [OUT_W-1:0] motor_c [4];

    always_comb
    begin : b5_calc
        logic signed [E2_W:0] v;
        for (int i = 0; i < 4; i++)
        begin
            v = (E2_W+1)'(b4_e2_reg[i]) + $signed({{(E2_W-OUT_W){1'b0}}, b4_t_reg});
            if (v < $signed({{(E2_W-MIN_W+1){1'b0}}, min_limit_reg}))
            begin
                v = $signed({{(E2_W-MIN_W+1){1'b0}}, min_limit_reg});
            end
            if (v > $signed({{(E2_W-MAX_W+1){1'b0}}, max_limit_reg}))
            begin
                v = $signed({{(E2_W-MAX_W+1){1'b0}}, max_limit_reg});
            end
            motor_c[i] = v[OUT_W-1:0];
        end
    end

    logic             done_reg;
    logic [OUT_W-1:0] motor_reg [4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= b4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        motor_reg <= motor_c;
    end

    assign done              = done_reg;
    assign motor_front_right = motor_reg[0];
    assign motor_front_left  = motor_reg[1];
    assign motor_rear_right  = motor_reg[2];
    assign motor_rear_left   = motor_reg[3];

endmodule

FILE: design/qxmm_checker.sv
// ----------------------------------------------------------------------------
// qxmm_checker: port-level checks of the quad X motor mixer
// Fixed latency from item to result and the output range of every motor.
// ----------------------------------------------------------------------------
module qxmm_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           start,
    input logic                           busy,
    input logic                           done,
    input logic [qxmm_pkg::OUT_W-1:0]     motor_front_right,
    input logic [qxmm_pkg::OUT_W-1:0]     motor_front_left,
    input logic [qxmm_pkg::OUT_W-1:0]     motor_rear_right,
    input logic [qxmm_pkg::OUT_W-1:0]     motor_rear_left
);
    import qxmm_pkg::*;

    // every item taken is followed by a result
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##27 done)
        else $error("item taken without a result 27 cycles later");

    // no result without an earlier item
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 27))
        else $error("result without a matching item");

    // motor commands never exceed 1.0
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (motor_front_right <= ONE && motor_front_left <= ONE
                  && motor_rear_right <= ONE && motor_rear_left <= ONE))
        else $error("motor command above full scale");

endmodule

bind quad_x_motor_mixer qxmm_checker u_qxmm_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .done              (done),
    .motor_front_right (motor_front_right),
    .motor_front_left  (motor_front_left),
    .motor_rear_right  (motor_rear_right),
    .motor_rear_left   (motor_rear_left)
);

FILE: tb/quad_x_motor_mixer_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// quad_x_motor_mixer_test: self-checking bench for the quad X motor mixer
// Feeds mixer items through the start/busy port, predicts the four motor
// commands in the bench and compares each done strobe against the oldest
// prediction. Limits are rewritten over APB between phases while idle.
// ----------------------------------------------------------------------------
module quad_x_motor_mixer_test;
    import qxmm_pkg::*;

    typedef struct packed {
        logic signed [IN_W-1:0] thr;
        logic signed [IN_W-1:0] roll;
        logic signed [IN_W-1:0] pitch;
        logic signed [IN_W-1:0] yaw;
    } mix_item_t;

    typedef struct packed {
        logic [OUT_W-1:0] fr;
        logic [OUT_W-1:0] fl;
        logic [OUT_W-1:0] rr;
        logic [OUT_W-1:0] rl;
    } motor_set_t;

    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 200000;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic signed [IN_W-1:0] throttle_in, roll_cmd, pitch_cmd, yaw_cmd;
    logic done;
    logic [OUT_W-1:0] motor_front_right, motor_front_left;
    logic [OUT_W-1:0] motor_rear_right, motor_rear_left;
    logic psel, penable, pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic pready;

    // bench copy of the limit registers
    longint lim_lo;
    longint lim_hi;

    mix_item_t  pending_items[$];
    motor_set_t expected_motors[$];
    int  mismatch_count;
    int  gap_left;
    bit  allow_gaps;
    int  cycle_count;

    quad_x_motor_mixer u_dut (.*);

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // timeout
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic longint scale_of(longint num, longint den);
        if (den == 0)
            return 0;
        return (num * 65536) / den;
    endfunction

    // desaturating mixer prediction
    function automatic motor_set_t mix_motors(mix_item_t it);
        longint t, r, p, y, mx, mn, s, v;
        longint m[4];
        motor_set_t res;
        logic [OUT_W-1:0] o[4];
        t = it.thr; r = it.roll; p = it.pitch; y = it.yaw;
        if (t < 0) t = 0;
        if (t > 65536) t = 65536;
        m[0] = t + r - p - y;
        m[1] = t - r - p + y;
        m[2] = t + r + p + y;
        m[3] = t - r + p - y;
        mx = m[0]; mn = m[0];
        for (int i = 1; i < 4; i++)
        begin
            if (m[i] > mx) mx = m[i];
            if (m[i] < mn) mn = m[i];
        end
        if (mx > lim_hi)
        begin
            s = scale_of(lim_hi - t, mx - t);
            for (int i = 0; i < 4; i++)
                m[i] = t + ((m[i] - t) * s) / 65536;
        end
        if (mn < lim_lo)
        begin
            s = scale_of(t - lim_lo, t - mn);
            for (int i = 0; i < 4; i++)
                m[i] = t - ((t - m[i]) * s) / 65536;
        end
        for (int i = 0; i < 4; i++)
        begin
            v = m[i];
            if (v < lim_lo) v = lim_lo;
            if (v > lim_hi) v = lim_hi;
            o[i] = v[OUT_W-1:0];
        end
        res.fr = o[0]; res.fl = o[1]; res.rr = o[2]; res.rl = o[3];
        return res;
    endfunction

    // driver: one item per accepted start, random gap bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            gap_left <= 0;
        end
        else
        begin
            // an accepted item leaves the queue, the next one is at its head
            if (start && !busy)
            begin
                expected_motors.push_back(mix_motors({throttle_in, roll_cmd,
                                                      pitch_cmd, yaw_cmd}));
                void'(pending_items.pop_front());
            end
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                start <= 1'b0;
            end
            else if (pending_items.size() > 0)
            begin
                mix_item_t nxt;
                nxt = pending_items[0];
                if (allow_gaps && $urandom_range(0, 5) == 0 && start && !busy)
                begin
                    start <= 1'b0;
                    gap_left <= $urandom_range(0, 7);
                end
                else
                begin
                    start <= 1'b1;
                    throttle_in <= nxt.thr;
                    roll_cmd <= nxt.roll;
                    pitch_cmd <= nxt.pitch;
                    yaw_cmd <= nxt.yaw;
                end
            end
            else
                start <= 1'b0;
        end
    end

    // monitor: compare each result with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_motors.size() == 0)
            begin
                mismatch_count <= mismatch_count + 1;
                if (mismatch_count < 10)
                    $display("unexpected result fr=%0d fl=%0d rr=%0d rl=%0d",
                             motor_front_right, motor_front_left,
                             motor_rear_right, motor_rear_left);
            end
            else
            begin
                motor_set_t e;
                e = expected_motors.pop_front();
                if (e.fr !== motor_front_right || e.fl !== motor_front_left ||
                    e.rr !== motor_rear_right || e.rl !== motor_rear_left)
                begin
                    mismatch_count <= mismatch_count + 1;
                    if (mismatch_count < 10)
                        $display("mismatch exp %0d %0d %0d %0d got %0d %0d %0d %0d",
                                 e.fr, e.fl, e.rr, e.rl, motor_front_right,
                                 motor_front_left, motor_rear_right,
                                 motor_rear_left);
                end
            end
        end
    end

    // APB register write, updates the bench copy
    task automatic write_limit(logic sel_max, logic [DATA_W-1:0] val);
        logic [OUT_W-1:0] v17;
        @(posedge clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {sel_max, 2'b00}; pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (sel_max == REG_MIN_LIMIT)
            lim_lo = val[MIN_W-1:0];
        else
        begin
            v17 = val[MAX_W-1:0];
            if (v17 > 0 && v17 <= 65536)
                lim_hi = v17;
        end
    endtask

    task automatic add_item(longint t, longint r, longint p, longint y);
        mix_item_t it;
        it.thr = IN_W'(t); it.roll = IN_W'(r); it.pitch = IN_W'(p); it.yaw = IN_W'(y);
        pending_items.push_back(it);
    endtask

    function automatic longint rand_field();
        case ($urandom_range(0, 3))
            0: return $signed(18'($urandom));
            1: return longint'($urandom_range(0, 70000));
            default: return longint'($urandom_range(0, 40000)) - 20000;
        endcase
    endfunction

    // wait for the pipeline to drain
    task automatic drain();
        while (pending_items.size() > 0 || start || expected_motors.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        paddr = '0; pwdata = '0;
        throttle_in = '0; roll_cmd = '0; pitch_cmd = '0; yaw_cmd = '0;
        mismatch_count = 0; cycle_count = 0; allow_gaps = 1'b1;
        lim_lo = 0; lim_hi = 65536;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes, zero divisor, saturation both ways
        add_item(0, 0, 0, 0);
        add_item(-131072, 0, 0, 0);
        add_item(131071, 0, 0, 0);
        add_item(32768, 131071, 131071, 131071);
        add_item(32768, -131072, -131072, -131072);
        add_item(65536, 20000, 0, 0);
        add_item(0, -20000, 5000, 100);
        add_item(-1, -131072, 131071, -131072);
        add_item(32768, 0, 0, 0);
        add_item(40000, 131071, -131072, 131071);
        drain();

        // limits inside range, both scaling paths and negative scale
        write_limit(REG_MIN_LIMIT, 32'd10000);
        write_limit(REG_MAX_LIMIT, 32'd50000);
        add_item(60000, 20000, 0, 0);
        add_item(5000, 3000, 1000, 0);
        add_item(30000, 40000, -1000, 7);
        add_item(0, 0, 0, 0);
        drain();

        // ignored writes, min above max, extremes
        write_limit(REG_MAX_LIMIT, 32'd0);
        write_limit(REG_MAX_LIMIT, 32'h1ffff);
        write_limit(REG_MIN_LIMIT, 32'hffffffff);
        add_item(30000, 100, 200, 300);
        add_item(65536, -131072, 131071, 0);
        drain();
        write_limit(REG_MAX_LIMIT, 32'd1);
        write_limit(REG_MIN_LIMIT, 32'd0);
        add_item(30000, 100, 200, 300);
        drain();

        // random phases over several limit settings
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: begin write_limit(REG_MIN_LIMIT, 0); write_limit(REG_MAX_LIMIT, 65536); end
                1: begin write_limit(REG_MIN_LIMIT, 8000); write_limit(REG_MAX_LIMIT, 60000); end
                2: begin write_limit(REG_MIN_LIMIT, $urandom); write_limit(REG_MAX_LIMIT, $urandom); end
                3: begin write_limit(REG_MIN_LIMIT, 65535); write_limit(REG_MAX_LIMIT, 65536); end
                4: begin write_limit(REG_MIN_LIMIT, $urandom_range(0, 30000));
                         write_limit(REG_MAX_LIMIT, $urandom_range(30000, 65536)); end
                default: begin write_limit(REG_MIN_LIMIT, 3000); write_limit(REG_MAX_LIMIT, 62000); end
            endcase
            allow_gaps = (ph < 5);
            for (int k = 0; k < 90; k++)
                add_item(rand_field(), rand_field(), rand_field(), rand_field());
            drain();
        end

        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

FILE: filelist.f
design/qxmm_pkg.sv
design/qxmm_div.sv
design/quad_x_motor_mixer.sv
design/qxmm_checker.sv
tb/quad_x_motor_mixer_test.sv
